/* src/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
// No dependencies.
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int OrderW = 4;
  localparam int StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_NOBLOCK = 3'd1,
    ST_DOUBLE  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_ORDER   = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;
endpackage

/* src/buddy_page_allocator.sv */
// Buddy page allocator top level: request/result handshake, sequencer, page store; uses bpa_pkg.
// Operation: alloc scans the whole store once per order tried (up to TOP+1 orders), splits one order
// per cycle, then clears 2^order pages; free checks 2^order pages, marks them free, then reads
// and merges the buddy at each merge step. Order and range errors answer in the cycle after acceptance.
// Throughput: one transaction at a time; a new one is taken once the result is drained.
// Reset: synchronous active-low; a clearing pass zeroes the store first.
`timescale 1ns / 1ps
module buddy_page_allocator #(
  parameter int PAGE_INDEX_BITS = 10,
  parameter int MAX_ORDER = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [bpa_pkg::OrderW-1:0] in_block_order,
  input  logic [9:0]                in_page_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bpa_pkg::StatusW-1:0] out_status,
  output logic [9:0]                out_base_page,
  output logic [bpa_pkg::OrderW-1:0] out_merged_order
);
  import bpa_pkg::*;

  localparam int PIB = PAGE_INDEX_BITS;
  localparam int TOP = (MAX_ORDER < PIB) ? MAX_ORDER : PIB;
  localparam int NP = 1 << PIB;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SPLIT, S_MARKA, S_CHECK, S_MARKF,
    S_MERGE_RD, S_MERGE, S_DONE
  } state_t;

  // page store: bit0 free, bit1 head, upper bits order
  logic [OrderW+1:0] mem [NP];
  logic [OrderW+1:0] rd_r;
  logic [PIB-1:0] ra, wa;
  logic we;
  logic [OrderW+1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  state_t state_r;
  logic [PIB:0] cnt_r;
  logic [PIB-1:0] base_r, addr_r;
  logic [OrderW-1:0] ord_r, cur_r, req_r;
  logic rdv_r;
  logic [PIB-1:0] scan_addr;

  logic [PIB:0] nblk;
  assign nblk = ({{PIB{1'b0}}, 1'b1} << req_r);

  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign scan_addr = cnt_r[PIB-1:0];

  // combinational store access per state
  always_comb begin
    ra = addr_r;
    we = 1'b0;
    wa = addr_r;
    wd = '0;
    case (state_r)
      S_CLEAR: begin we = 1'b1; wa = scan_addr; end
      S_SCAN: ra = scan_addr;
      S_CHECK: ra = base_r | scan_addr;
      S_SPLIT: begin
        we = 1'b1;
        wa = base_r ^ PIB'((NP)'(1) << (cur_r - 1'b1));
        wd = {cur_r - 1'b1, 1'b1, 1'b1};
      end
      S_MARKA: begin we = 1'b1; wa = base_r | scan_addr; end
      S_MARKF: begin we = 1'b1; wa = base_r | scan_addr; wd = {{OrderW{1'b0}}, 1'b0, 1'b1}; end
      S_MERGE_RD: ra = base_r ^ PIB'((NP)'(1) << ord_r);
      S_MERGE: begin
        if (ord_r < OrderW'(TOP) && rd_r[1] && rd_r[OrderW+1:2] == ord_r) begin
          we = 1'b1;
          wa = base_r ^ PIB'((NP)'(1) << ord_r);
          wd = {{OrderW{1'b0}}, 1'b0, 1'b1};
        end else begin
          we = 1'b1;
          wa = base_r;
          wd = {ord_r, 1'b1, 1'b1};
        end
      end
      default: ;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      out_valid <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (cnt_r[PIB-1:0] == '1) begin cnt_r <= '0; state_r <= S_IDLE; end
          else cnt_r <= cnt_r + 1'b1;
        end
        S_IDLE: if (in_valid && in_ready) begin
          req_r <= in_block_order;
          cnt_r <= '0;
          rdv_r <= 1'b0;
          out_base_page <= '0;
          out_merged_order <= '0;
          if (in_block_order > OrderW'(TOP)) begin
            out_status <= ST_ORDER; out_valid <= 1'b1;
          end else if (in_operation == OP_ALLOC) begin
            cur_r <= in_block_order; state_r <= S_SCAN;
          end else if ((PIB < 10 && (in_page_index >> PIB) != '0) ||
                       ((in_page_index & 10'(((1 << in_block_order)) - 1)) != '0)) begin
            out_status <= ST_RANGE; out_valid <= 1'b1;
          end else begin
            base_r <= PIB'(in_page_index); state_r <= S_CHECK;
          end
        end
        S_SCAN: begin
          // one read in flight; rdv_r marks data for address cnt_r-1
          addr_r <= scan_addr;
          if (rdv_r && rd_r[1] && rd_r[OrderW+1:2] == cur_r) begin
            base_r <= addr_r; ord_r <= cur_r; state_r <= S_SPLIT; rdv_r <= 1'b0;
          end else if (rdv_r && addr_r == '1) begin
            rdv_r <= 1'b0; cnt_r <= '0;
            if (cur_r == OrderW'(TOP)) begin
              out_status <= ST_NOBLOCK; out_valid <= 1'b1; state_r <= S_IDLE;
            end else cur_r <= cur_r + 1'b1;
          end else begin
            rdv_r <= 1'b1;
            if (!(rdv_r && cnt_r == '0)) begin
              cnt_r <= (cnt_r[PIB-1:0] == '1) ? '0 : cnt_r + 1'b1;
            end
          end
        end
        S_SPLIT: begin
          if (cur_r == req_r) begin cnt_r <= '0; state_r <= S_MARKA; end
          else cur_r <= cur_r - 1'b1;
        end
        S_MARKA: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r + 1'b1 == nblk) begin
            out_status <= ST_OK; out_base_page <= 10'(base_r);
            out_valid <= 1'b1; state_r <= S_IDLE;
          end
        end
        S_CHECK: begin
          addr_r <= scan_addr;
          if (rdv_r && rd_r[0]) begin
            out_status <= ST_DOUBLE; out_valid <= 1'b1; state_r <= S_IDLE; rdv_r <= 1'b0;
          end else if (rdv_r && (PIB+1)'(addr_r) + 1'b1 == nblk) begin
            cnt_r <= '0; rdv_r <= 1'b0; state_r <= S_MARKF;
          end else begin
            rdv_r <= 1'b1;
            if ((PIB+1)'(cnt_r) + 1'b1 < nblk) cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MARKF: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r + 1'b1 == nblk) begin ord_r <= req_r; state_r <= S_MERGE_RD; end
        end
        S_MERGE_RD: state_r <= S_MERGE;
        S_MERGE: begin
          if (ord_r < OrderW'(TOP) && rd_r[1] && rd_r[OrderW+1:2] == ord_r) begin
            base_r <= base_r & ~PIB'((NP)'(1) << ord_r);
            ord_r <= ord_r + 1'b1;
            state_r <= S_MERGE_RD;
          end else begin
            out_status <= ST_OK; out_base_page <= 10'(base_r);
            out_merged_order <= ord_r; out_valid <= 1'b1; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/bpa_checker.sv */
// Port-level checker for the buddy page allocator, bound to the top level.
// Uses bpa_pkg.
`timescale 1ns / 1ps
module bpa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_status,
  input logic [9:0] out_base_page,
  input logic [3:0] out_merged_order
);
  import bpa_pkg::*;
  // no new transaction while a result is pending
  a_one: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("accepted with result pending");
  // error results carry zero fields
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_base_page == '0 && out_merged_order == '0))
    else $error("error result with payload");
  // status code in range
  a_st: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> out_status <= ST_ORDER)
    else $error("bad status");
  // held result stays valid and its status stable
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");
endmodule

bind buddy_page_allocator bpa_checker u_chk (.*);

/* dv/buddy_page_allocator_tb.sv */
// Self-checking testbench for buddy_page_allocator: directed corner cases, then random traffic.
// Depends on bpa_pkg and buddy_page_allocator; the scoreboard class holds its own pool model.
`timescale 1ns / 1ps
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NumPages = 1024;
  localparam int TopOrder = 10;
  localparam int RandItems = 275;
  localparam longint CycleLimit = 20_000_000;

  typedef struct {
    status_t     status;
    logic [9:0]  base_page;
    logic [3:0]  merged_order;
  } alloc_result_t;

  // Pool model plus the queue of results still owed by the block
  class pool_scoreboard;
    bit          page_free[NumPages];
    bit          free_head[NumPages];
    logic [3:0]  head_order[NumPages];
    alloc_result_t owed[$];
    int          errors;

    function alloc_result_t allocate(int ord);
      alloc_result_t r;
      int base, lvl;
      bit found;
      r = '{ST_NOBLOCK, 10'd0, 4'd0};
      found = 0;
      base = 0;
      lvl = ord;
      // Lowest address head at the smallest usable order
      for (int i = ord; i <= TopOrder && !found; i++) begin
        for (int p = 0; p < NumPages && !found; p++) begin
          if (free_head[p] && head_order[p] == i) begin
            base = p;
            lvl = i;
            found = 1;
          end
        end
      end
      if (!found) return r;
      free_head[base] = 0;
      head_order[base] = 0;
      // Split off upper halves as smaller free heads
      for (int j = lvl; j > ord; j--) begin
        free_head[base ^ (1 << (j - 1))] = 1;
        head_order[base ^ (1 << (j - 1))] = 4'(j - 1);
      end
      for (int p = 0; p < (1 << ord); p++) begin
        page_free[base + p] = 0;
        free_head[base + p] = 0;
        head_order[base + p] = 0;
      end
      r = '{ST_OK, base[9:0], 4'd0};
      return r;
    endfunction

    function alloc_result_t release_block(int base, int ord);
      alloc_result_t r;
      int n, buddy;
      r = '{ST_RANGE, 10'd0, 4'd0};
      n = 1 << ord;
      if (base >= NumPages || (base & (n - 1)) != 0) return r;
      r.status = ST_DOUBLE;
      for (int p = 0; p < n; p++)
        if (page_free[base + p]) return r;
      for (int p = 0; p < n; p++) begin
        page_free[base + p] = 1;
        free_head[base + p] = 0;
        head_order[base + p] = 0;
      end
      // Coalesce with the buddy while it is a free head of the same order
      while (ord < TopOrder) begin
        buddy = base ^ (1 << ord);
        if (!free_head[buddy] || head_order[buddy] != ord) break;
        free_head[buddy] = 0;
        head_order[buddy] = 0;
        if (buddy < base) base = buddy;
        ord++;
      end
      free_head[base] = 1;
      head_order[base] = 4'(ord);
      r = '{ST_OK, base[9:0], ord[3:0]};
      return r;
    endfunction

    function alloc_result_t note_request(op_t op, int ord, int page);
      alloc_result_t r;
      if (ord > TopOrder) r = '{ST_ORDER, 10'd0, 4'd0};
      else if (op == OP_ALLOC) r = allocate(ord);
      else r = release_block(page, ord);
      owed.push_back(r);
      return r;
    endfunction

    function void check_result(logic [2:0] st, logic [9:0] bp, logic [3:0] mo);
      alloc_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result status=%0d base=%0d order=%0d", $time, st, bp, mo);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (bp !== e.base_page) begin
        $display("%0t: base_page expected %0d actual %0d", $time, e.base_page, bp);
        errors++;
      end
      if (mo !== e.merged_order) begin
        $display("%0t: merged_order expected %0d actual %0d", $time, e.merged_order, mo);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic       in_operation = 0;
  logic [3:0] in_block_order = 0;
  logic [9:0] in_page_index = 0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [2:0] out_status;
  logic [9:0] out_base_page;
  logic [3:0] out_merged_order;

  pool_scoreboard sb = new();
  bit     steady_send = 0;
  longint cycles = 0;
  int     held_base[$];
  int     held_order[$];

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_block_order(in_block_order),
    .in_page_index(in_page_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_base_page(out_base_page),
    .out_merged_order(out_merged_order)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Throttle the result side, with a calm window in the middle of the run
  always @(posedge clk) begin
    if (cycles > 40_000 && cycles < 120_000) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_base_page, out_merged_order);
  end

  // Abort on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drive one transaction and hold it until accepted
  task automatic send(op_t op, int ord, int page);
    alloc_result_t r;
    if (!steady_send && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_block_order <= ord[3:0];
    in_page_index <= page[9:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = sb.note_request(op, ord, page);
    if (op == OP_ALLOC && r.status == ST_OK) begin
      held_base.push_back(r.base_page);
      held_order.push_back(ord);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    int k, ord, sel;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pool, bad orders, misaligned, double free, coalescing
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 15, 1023);
    send(OP_FREE, 11, 0);
    send(OP_FREE, 1, 1);
    send(OP_FREE, 0, 1023);
    send(OP_FREE, 0, 1022);
    send(OP_FREE, 1, 1022);
    send(OP_FREE, 10, 0);
    send(OP_FREE, 9, 0);
    send(OP_ALLOC, 10, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 0, 682);
    send(OP_FREE, 9, 512);
    send(OP_FREE, 0, 0);
    send(OP_FREE, 1, 1022);
    send(OP_ALLOC, 10, 341);
    send(OP_FREE, 10, 0);
    held_base.delete();
    held_order.delete();

    // Let the pipe empty completely before the random phase
    wait_drained();

    for (int n = 0; n < RandItems; n++) begin
      steady_send = (n >= 100 && n < 160);
      sel = $urandom_range(99);
      if (sel < 55 || held_base.size() == 0) begin
        k = $urandom_range(99);
        ord = (k < 70) ? $urandom_range(3) : (k < 95) ? $urandom_range(4, 7)
                                                     : $urandom_range(8, 15);
        send(OP_ALLOC, ord, $urandom_range(1023));
      end else if (sel < 90) begin
        // Return a block that is really held; now and then free it twice
        k = $urandom_range(held_base.size() - 1);
        send(OP_FREE, held_order[k], held_base[k]);
        if ($urandom_range(9) == 0) send(OP_FREE, held_order[k], held_base[k]);
        held_base.delete(k);
        held_order.delete(k);
      end else begin
        send(OP_FREE, $urandom_range(15), $urandom_range(1023));
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
